/* rtl/lpd_pkg.sv */
package lpd_pkg;

  typedef enum logic [1:0] {
    MODE_SNIFF  = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_FRAMED = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       raw;
    logic       eom;
  } res_t;

  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_T = 8'h54;

  // bytes held back before the connection type is known
  localparam logic [1:0] SNIFF_HOLD = 2'd2;
  // index of the last word of the raw burst that flushes the sniffed bytes
  localparam logic [1:0] BURST_LAST = 2'd2;

endpackage

/* rtl/lpd_core.sv */
module lpd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  input  logic [7:0]      in_rx_byte,
  output logic            in_stall,
  output logic            res_valid,
  output lpd_pkg::res_t   res,
  input  logic            res_ready
);

  lpd_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     sniff_cnt_r, sniff_cnt_nxt;
  logic [1:0]     burst_r, burst_nxt;
  logic [7:0]     held_r [2];
  logic [7:0]     held_nxt [2];
  logic           hdr_pending_r, hdr_pending_nxt;
  logic [7:0]     fhb_r, fhb_nxt;
  logic [15:0]    rem_r, rem_nxt;
  logic           big_endian_r;
  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic           done;
  logic           in_accept;
  logic           is_get;
  logic [15:0]    sniff_len;
  logic [15:0]    hdr_len;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = s1_valid_r && !done;

  assign is_get = (held_r[0] == lpd_pkg::CHAR_G) && (held_r[1] == lpd_pkg::CHAR_E) &&
                  (s1_byte_r == lpd_pkg::CHAR_T);
  // header made of the two held bytes when the connection turns out framed
  assign sniff_len = big_endian_r ? {held_r[0], held_r[1]} : {held_r[1], held_r[0]};
  assign hdr_len   = big_endian_r ? {fhb_r, s1_byte_r} : {s1_byte_r, fhb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
    end else if (cfg_wr_en) begin
      big_endian_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
    held_r[0] <= held_nxt[0];
    held_r[1] <= held_nxt[1];
    fhb_r     <= fhb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= lpd_pkg::MODE_SNIFF;
      sniff_cnt_r   <= 2'd0;
      burst_r       <= 2'd0;
      hdr_pending_r <= 1'b0;
      rem_r         <= 16'd0;
    end else begin
      mode_r        <= mode_nxt;
      sniff_cnt_r   <= sniff_cnt_nxt;
      burst_r       <= burst_nxt;
      hdr_pending_r <= hdr_pending_nxt;
      rem_r         <= rem_nxt;
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    sniff_cnt_nxt   = sniff_cnt_r;
    burst_nxt       = burst_r;
    held_nxt[0]     = held_r[0];
    held_nxt[1]     = held_r[1];
    hdr_pending_nxt = hdr_pending_r;
    fhb_nxt         = fhb_r;
    rem_nxt         = rem_r;
    done            = 1'b0;
    res_valid       = 1'b0;
    res.data        = s1_byte_r;
    res.raw         = 1'b0;
    res.eom         = 1'b0;
    if (s1_valid_r) begin
      unique case (mode_r)
        lpd_pkg::MODE_SNIFF: begin
          if (sniff_cnt_r != lpd_pkg::SNIFF_HOLD) begin
            held_nxt[sniff_cnt_r[0]] = s1_byte_r;
            sniff_cnt_nxt = sniff_cnt_r + 2'd1;
            done = 1'b1;
          end else if (is_get) begin
            // flush the three sniffed bytes as raw words, one per cycle while res_ready is high
            res_valid = 1'b1;
            res.raw   = 1'b1;
            if (burst_r == 2'd0) begin
              res.data = held_r[0];
            end else if (burst_r == 2'd1) begin
              res.data = held_r[1];
            end
            if (res_ready) begin
              if (burst_r == lpd_pkg::BURST_LAST) begin
                burst_nxt = 2'd0;
                mode_nxt  = lpd_pkg::MODE_RAW;
                done      = 1'b1;
              end else begin
                burst_nxt = burst_r + 2'd1;
              end
            end
          end else if (sniff_len != 16'd0) begin
            // held bytes form the first header, this byte is its first payload
            res_valid = 1'b1;
            res.eom   = (sniff_len == 16'd1);
            if (res_ready) begin
              mode_nxt = lpd_pkg::MODE_FRAMED;
              rem_nxt  = sniff_len - 16'd1;
              done     = 1'b1;
            end
          end else begin
            // empty first message, this byte opens the next header
            mode_nxt        = lpd_pkg::MODE_FRAMED;
            fhb_nxt         = s1_byte_r;
            hdr_pending_nxt = 1'b1;
            done            = 1'b1;
          end
        end
        lpd_pkg::MODE_RAW: begin
          res_valid = 1'b1;
          res.raw   = 1'b1;
          done      = res_ready;
        end
        default: begin
          if (rem_r != 16'd0) begin
            res_valid = 1'b1;
            res.eom   = (rem_r == 16'd1);
            if (res_ready) begin
              rem_nxt = rem_r - 16'd1;
              done    = 1'b1;
            end
          end else if (!hdr_pending_r) begin
            fhb_nxt         = s1_byte_r;
            hdr_pending_nxt = 1'b1;
            done            = 1'b1;
          end else begin
            rem_nxt         = hdr_len;
            hdr_pending_nxt = 1'b0;
            done            = 1'b1;
          end
        end
      endcase
    end
  end

  a_burst_only_sniff: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r != 2'd0 |-> mode_r == lpd_pkg::MODE_SNIFF && s1_valid_r && is_get)
    else $error("raw burst active outside the sniff of a GET");

  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != lpd_pkg::MODE_SNIFF |=> mode_r != lpd_pkg::MODE_SNIFF)
    else $error("connection returned to sniffing");

  a_no_header_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 16'd0 |-> !hdr_pending_r)
    else $error("header pending while payload is due");

  a_blocked_word_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |-> in_stall)
    else $error("input taken while a result word is blocked");

  a_raw_no_eom: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && mode_r == lpd_pkg::MODE_RAW |-> res.raw && !res.eom)
    else $error("raw word carries framing marks");

endmodule

/* rtl/lpd_out_reg.sv */
module lpd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  lpd_pkg::res_t   push,
  output logic            push_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_raw_mode,
  output logic            out_end_of_message
);

  logic          valid_r;
  lpd_pkg::res_t data_r;

  assign push_ready         = !valid_r || !out_stall;
  assign out_valid          = valid_r;
  assign out_byte           = data_r.data;
  assign out_raw_mode       = data_r.raw;
  assign out_end_of_message = data_r.eom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      data_r <= push;
    end
  end

endmodule

/* rtl/length_prefix_deframer_top.sv */
// channel   ports                                              direction
// in        in_valid, in_stall, in_rx_byte                     byte stream in
// out       out_valid, out_stall, out_byte, out_raw_mode,      payload word out
//           out_end_of_message
// cfg       cfg_wr_en, cfg_wr_data (length_big_endian)         register write
//
// one word per clock in steady state while out_stall is low: a word passes
// through the input register, then through the output register
// a GET holds its third word in the input register to flush the sniffed bytes
// synchronous active-low reset puts the block back to sniffing a new connection
// out_stall holds the output register and, through it, the input register
module length_prefix_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_raw_mode,
  output logic       out_end_of_message
);

  logic          res_valid;
  logic          res_ready;
  lpd_pkg::res_t res;

  lpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  lpd_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .push_valid        (res_valid),
    .push              (res),
    .push_ready        (res_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_raw_mode      (out_raw_mode),
    .out_end_of_message(out_end_of_message)
  );

endmodule
